FILE: sv/assert_macros.svh
// Assertion helpers for the property checker in sv/lpcsf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked while reset is high.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lpcsf_pkg.sv
package lpcsf_pkg;

  localparam int ORDER          = 14;
  localparam int COEF_FRAC_BITS = 12;
  localparam int ACC_BITS       = 40;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int IDX_W    = 4;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int PRED_W   = ACC_BITS - COEF_FRAC_BITS;
  localparam int SUM_W    = PRED_W + 1;
  localparam int TAP_W    = (ORDER > 1) ? $clog2(ORDER) : 1;

  // Stream packing: tdata holds coef_index, coef_value, excitation, padded to bytes.
  localparam int IN_FIELDS_W = IDX_W + COEF_W + SAMPLE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = SAMPLE_W;

  localparam int COEF_LSB = IDX_W;
  localparam int EXC_LSB  = IDX_W + COEF_W;

  // Item kinds carried in s_axis_tuser.
  localparam logic MODE_FILTER = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Controller to datapath commands.
  typedef struct packed {
    logic             coef_wr;
    logic             start;
    logic             mul_en;
    logic             acc_en;
    logic [TAP_W-1:0] tap;
    logic             trunc_en;
    logic             out_load;
  } lpcsf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } lpcsf_stat_t;

endpackage

FILE: sv/lpc_synthesis_filter_top.sv
// All-pole LPC synthesis filter, order 14.
//
// Input stream (s_axis): one request per item. s_axis_tuser selects the kind:
// a filter request carries an excitation sample, a load request writes one
// predictor coefficient (slots 14 and up are dropped, nothing is returned).
// Output stream (m_axis): one synthesized sample per filter request, with
// s_axis_tuser-style flag m_axis_tuser set when the sum was saturated.
//
// Sequencing: a load request is taken at once and leaves the block ready.
// A filter request runs one shared 16x16 multiplier over the 14 taps, one
// tap a cycle, then adds the last product, truncates and saturates into the
// output register (states MUL, ADD, TRUNC, FIN). No new request is taken
// until the sample is in the output register; the tap walk through the
// single multiplier is what keeps the block busy that long.
//
// Reset clears all coefficients, the output history and both handshakes.
// While the receiver stalls, the result waits in the output register; load
// requests are still taken, and a following filter request computes in full
// and holds in its final step until the register is free.
module lpc_synthesis_filter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [3:0] coef_index, [19:4] coef_value, [35:20] excitation, [39:36] zero
  input  logic [lpcsf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] mode: 0 filter, 1 load coefficient
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [15:0] sample_out
  output logic [lpcsf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [0] clipped
  output logic                                  m_axis_tuser
);
  import lpcsf_pkg::*;

  lpcsf_cmd_t                 cmd;
  lpcsf_stat_t                stat;
  logic [IDX_W-1:0]           coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [SAMPLE_W-1:0] excitation;
  logic signed [SAMPLE_W-1:0] sample_out;

  // Unpack the request fields.
  assign coef_index = s_axis_tdata[IDX_W-1:0];
  assign coef_value = s_axis_tdata[COEF_LSB +: COEF_W];
  assign excitation = s_axis_tdata[EXC_LSB +: SAMPLE_W];

  assign m_axis_tdata = sample_out;

  lpcsf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .mode       (s_axis_tuser),
    .coef_index (coef_index),
    .stat       (stat),
    .in_ready   (s_axis_tready),
    .cmd        (cmd)
  );

  lpcsf_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .excitation (excitation),
    .out_ready  (m_axis_tready),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .sample_out (sample_out),
    .clipped    (m_axis_tuser)
  );

endmodule

FILE: sv/lpcsf_ctrl.sv
module lpcsf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      mode,
  input  logic [lpcsf_pkg::IDX_W-1:0] coef_index,
  input  lpcsf_pkg::lpcsf_stat_t    stat,
  output logic                      in_ready,
  output lpcsf_pkg::lpcsf_cmd_t     cmd
);
  import lpcsf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_TRUNC = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER - 1);

  state_t           state, state_next;
  logic [TAP_W-1:0] tap, tap_next;
  logic             accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    tap_next     = tap;
    cmd          = '0;
    cmd.tap      = tap;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_LOAD) begin
            // drop writes beyond the last tap
            cmd.coef_wr = (32'(coef_index) < ORDER);
          end else begin
            cmd.start  = 1'b1;
            tap_next   = '0;
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.acc_en = (tap != '0);
        if (tap == LAST_TAP) begin
          state_next = ST_ADD;
        end else begin
          tap_next = tap + TAP_W'(1);
        end
      end
      ST_ADD: begin
        cmd.acc_en = 1'b1;
        state_next = ST_TRUNC;
      end
      ST_TRUNC: begin
        cmd.trunc_en = 1'b1;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the sample
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

endmodule

FILE: sv/lpcsf_datapath.sv
module lpcsf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  lpcsf_pkg::lpcsf_cmd_t               cmd,
  input  logic [lpcsf_pkg::IDX_W-1:0]         coef_index,
  input  logic signed [lpcsf_pkg::COEF_W-1:0] coef_value,
  input  logic signed [lpcsf_pkg::SAMPLE_W-1:0] excitation,
  input  logic                                out_ready,
  output lpcsf_pkg::lpcsf_stat_t              stat,
  output logic                                out_valid,
  output logic signed [lpcsf_pkg::SAMPLE_W-1:0] sample_out,
  output logic                                clipped
);
  import lpcsf_pkg::*;

  localparam logic signed [ACC_BITS-1:0] TRUNC_BIAS = ACC_BITS'((1 << COEF_FRAC_BITS) - 1);
  localparam logic signed [SUM_W-1:0]    SUM_MAX    = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0]    SUM_MIN    = SUM_W'(SAMPLE_MIN);

  logic signed [COEF_W-1:0]   coef [ORDER];
  logic signed [SAMPLE_W-1:0] hist [ORDER];
  logic signed [SAMPLE_W-1:0] exc;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_BITS-1:0] acc;
  logic signed [ACC_BITS-1:0] acc_bias;
  logic signed [ACC_BITS-1:0] acc_rnd;
  logic signed [PRED_W-1:0]   pred;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       sat_hit;

  // Truncate toward zero: bias negative sums before dropping fraction bits.
  assign acc_bias = acc[ACC_BITS-1] ? TRUNC_BIAS : '0;
  assign acc_rnd  = acc + acc_bias;

  assign sum = SUM_W'(pred) + SUM_W'(exc);

  always_comb begin
    sat     = sum[SAMPLE_W-1:0];
    sat_hit = 1'b0;
    if (sum > SUM_MAX) begin
      sat     = SAMPLE_MAX;
      sat_hit = 1'b1;
    end else if (sum < SUM_MIN) begin
      sat     = SAMPLE_MIN;
      sat_hit = 1'b1;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER; i++) begin
        coef[i] <= '0;
        hist[i] <= '0;
      end
    end else begin
      if (cmd.coef_wr) begin
        coef[TAP_W'(coef_index)] <= coef_value;
      end
      if (cmd.out_load) begin
        hist[0] <= sat;
        for (int i = 1; i < ORDER; i++) begin
          hist[i] <= hist[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      exc <= excitation;
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + ACC_BITS'(prod);
    end
    if (cmd.mul_en) begin
      prod <= coef[cmd.tap] * hist[cmd.tap];
    end
    if (cmd.trunc_en) begin
      pred <= acc_rnd[ACC_BITS-1:COEF_FRAC_BITS];
    end
    if (cmd.out_load) begin
      sample_out <= sat;
      clipped    <= sat_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/lpcsf_checker.sv
`include "assert_macros.svh"

module lpcsf_props (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [lpcsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic m_axis_tuser
);
  import lpcsf_pkg::*;

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds.
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Reset empties the output register.
  `ASSERT_CLK_ALWAYS(a_rst_empty, clk, rst |=> !m_axis_tvalid, "result valid right after reset")

  // A filter request occupies the block: no request in the next cycle.
  `ASSERT_CLK(a_filter_busy, clk, rst, s_acc && (s_axis_tuser == MODE_FILTER) |=> !s_axis_tready, "request taken during filtering")

  // A load request finishes at once: ready again in the next cycle.
  `ASSERT_CLK(a_load_quick, clk, rst, s_acc && (s_axis_tuser == MODE_LOAD) |=> s_axis_tready, "load request kept the block busy")

endmodule

bind lpc_synthesis_filter_top lpcsf_props u_lpcsf_props (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/lpcsf_checker.sv
`timescale 1ns / 1ps

module lpcsf_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [lpcsf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [lpcsf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                              m_axis_tuser,
  output int                                fail_count,
  output int                                pending
);
  import lpcsf_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } synth_t;

  logic signed [COEF_W-1:0]   coef_mem [ORDER];
  logic signed [SAMPLE_W-1:0] hist_mem [ORDER];
  synth_t                     synth_q [$];
  int                         errs = 0;

  // All-pole step: sum the taps, truncate toward zero, add, saturate, push history.
  function automatic synth_t synthesize(logic signed [SAMPLE_W-1:0] exc);
    logic signed [ACC_BITS-1:0] acc;
    logic signed [PROD_W-1:0]   prod;
    longint                     a;
    longint                     pred;
    longint                     total;
    synth_t                     res;
    acc = '0;
    for (int n = 0; n < ORDER; n++) begin
      prod = coef_mem[n] * hist_mem[n];
      acc  = acc + {{(ACC_BITS-PROD_W){prod[PROD_W-1]}}, prod};
    end
    a = longint'(acc);
    if (a < 0) pred = -((-a) >> COEF_FRAC_BITS);
    else pred = a >> COEF_FRAC_BITS;
    total    = pred + longint'(exc);
    res.clip = 1'b0;
    if (total > longint'(SAMPLE_MAX)) begin
      total    = longint'(SAMPLE_MAX);
      res.clip = 1'b1;
    end else if (total < longint'(SAMPLE_MIN)) begin
      total    = longint'(SAMPLE_MIN);
      res.clip = 1'b1;
    end
    res.sample = total[SAMPLE_W-1:0];
    for (int n = ORDER - 1; n > 0; n--) hist_mem[n] = hist_mem[n-1];
    hist_mem[0] = res.sample;
    return res;
  endfunction

  always @(posedge clk) begin
    synth_t want;
    logic [IDX_W-1:0] idx;
    if (rst) begin
      for (int n = 0; n < ORDER; n++) begin
        coef_mem[n] = '0;
        hist_mem[n] = '0;
      end
      synth_q.delete();
    end else begin
      // Retire the result first: a request taken at this edge cannot be answered yet.
      if (m_axis_tvalid && m_axis_tready) begin
        if (synth_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected sample %0d clipped %0b", $time,
                     $signed(m_axis_tdata), m_axis_tuser);
        end else begin
          want = synth_q.pop_front();
          if (m_axis_tdata !== want.sample || m_axis_tuser !== want.clip) begin
            errs++;
            if (errs <= 10)
              $display("%0t: sample exp %0d got %0d, clipped exp %0b got %0b", $time,
                       want.sample, $signed(m_axis_tdata), want.clip, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == MODE_LOAD) begin
          idx = s_axis_tdata[IDX_W-1:0];
          if (int'(idx) < ORDER) coef_mem[idx] = s_axis_tdata[COEF_LSB +: COEF_W];
        end else begin
          synth_q.push_back(synthesize(s_axis_tdata[EXC_LSB +: SAMPLE_W]));
        end
      end
    end
    fail_count <= errs;
    pending    <= synth_q.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lpcsf_pkg::*;

  localparam int TOTAL_ITEMS  = 550;
  localparam int CYCLE_LIMIT  = 200000;
  // Quiet window of requests in which neither side idles.
  localparam int CALM_FIRST   = 200;
  localparam int CALM_LAST    = 320;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = MODE_FILTER;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int   fail_count;
  int   pending;
  int   req_count = 0;
  int   cycle_cnt = 0;
  logic calm      = 1'b0;

  always #4 clk = ~clk;

  lpc_synthesis_filter_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lpcsf_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Stall the receiver at random, except inside the calm window.
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= 31);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive one request from a falling edge and hold it until it is taken.
  // Return at the falling edge after the handshake.
  task automatic send_request(input logic mode, input logic [IDX_W-1:0] idx,
                              input logic [COEF_W-1:0] cv, input logic [SAMPLE_W-1:0] exc);
    calm = (req_count >= CALM_FIRST) && (req_count < CALM_LAST);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(IN_TDATA_W-IN_FIELDS_W){1'b0}}, exc, cv, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // Ignored loads do not count toward the request budget.
    if (mode == MODE_FILTER || int'(idx) < ORDER) req_count++;
    @(negedge clk);
  endtask

  // Uniform value in [-span, span], as a 16-bit pattern.
  function automatic logic [15:0] rand_span(int span);
    int v;
    v = int'($urandom_range(2 * span)) - span;
    return v[15:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_excitation();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return rand_span(2000);
    if (pick < 85) return SAMPLE_W'($urandom_range(16'hFFFF));
    return pick[0] ? SAMPLE_MAX : SAMPLE_MIN;
  endfunction

  // Load a random number of taps with values from the chosen style.
  task automatic load_taps(input int style);
    int               cnt;
    logic [IDX_W-1:0] idx;
    logic [COEF_W-1:0] cv;
    cnt = $urandom_range(1, ORDER);
    repeat (cnt) begin
      // Occasionally aim past the last tap: the block must drop it.
      if ($urandom_range(9) == 0) idx = IDX_W'($urandom_range(ORDER, 2**IDX_W - 1));
      else idx = IDX_W'($urandom_range(ORDER - 1));
      if (style <= 5) cv = rand_span(280);        // sum of |taps| below one: decays
      else if (style <= 7) cv = COEF_W'($urandom_range(16'hFFFF));
      else cv = rand_span(1500);
      send_request(MODE_LOAD, idx, cv, SAMPLE_W'($urandom_range(16'hFFFF)));
    end
  endtask

  initial begin
    int  style;
    int  run_len;
    bit  drained;
    drained = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Taps are zero after reset: samples pass straight through.
    send_request(MODE_FILTER, '0, '0, SAMPLE_MAX);
    send_request(MODE_FILTER, '0, '0, SAMPLE_MIN);
    // Filter requests ignore the index and coefficient fields.
    send_request(MODE_FILTER, '1, '1, '0);
    send_request(MODE_FILTER, '0, '0, '1);
    // Loads past the last tap are dropped.
    send_request(MODE_LOAD, 4'd15, SAMPLE_MAX, '0);
    send_request(MODE_LOAD, 4'd14, SAMPLE_MIN, '1);
    // Largest positive tap; the excitation field is ignored on loads.
    send_request(MODE_LOAD, 4'd0, SAMPLE_MAX, '1);
    // History -1: negative prediction truncates toward zero.
    send_request(MODE_FILTER, '0, '0, SAMPLE_MAX);
    // Large positive prediction: saturate high.
    send_request(MODE_FILTER, '0, '0, SAMPLE_MAX);
    // Most negative tap: saturate low.
    send_request(MODE_LOAD, 4'd0, SAMPLE_MIN, '0);
    send_request(MODE_FILTER, '0, '0, SAMPLE_MIN);
    // Smallest negative tap: a small negative sum rounds to zero, not to -1.
    send_request(MODE_LOAD, 4'd0, 16'hFFFF, '0);
    send_request(MODE_FILTER, '0, '0, '0);
    send_request(MODE_FILTER, '0, '0, '0);
    // Spread a few taps over the line, then walk the history through them.
    send_request(MODE_LOAD, 4'd13, 16'h0800, '0);
    send_request(MODE_LOAD, 4'd7, 16'hF800, '0);
    send_request(MODE_LOAD, 4'd0, 16'h0400, '0);
    send_request(MODE_FILTER, '0, '0, 16'h4000);
    send_request(MODE_FILTER, '0, '0, 16'hC000);
    send_request(MODE_FILTER, '0, '0, 16'h0001);

    // Random part: frames of tap loads followed by runs of samples.
    while (req_count < TOTAL_ITEMS) begin
      style = $urandom_range(9);
      load_taps(style);
      run_len = $urandom_range(4, 30);
      repeat (run_len) begin
        if ($urandom_range(9) == 0)
          send_request(MODE_LOAD, IDX_W'($urandom_range(2**IDX_W - 1)),
                       COEF_W'($urandom_range(16'hFFFF)),
                       SAMPLE_W'($urandom_range(16'hFFFF)));
        else
          send_request(MODE_FILTER, IDX_W'($urandom_range(2**IDX_W - 1)),
                       COEF_W'($urandom_range(16'hFFFF)), rand_excitation());
      end
      // Once, hold off the sender until every sample has come back.
      if (!drained && req_count >= 400) begin
        drained = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow time for any stray result to show up.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
